[sv/mcfrc_pkg.sv]
// Package for the matrix column fix and row combine block.
// Holds sizes, kind and status codes and the Q16.16 helpers; no dependencies.
`timescale 1ns / 1ps
package mcfrc_pkg;
   localparam int MaxUnknowns = 31;
   localparam int MaxRows = 256;
   localparam int NCols = MaxUnknowns + 1;
   localparam int ColW = 5;
   localparam int RowW = 8;
   localparam int AddrW = RowW + ColW;

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_RESERVE = 2'd1;
   localparam logic [1:0] KIND_COMBINE = 2'd2;
   localparam logic [1:0] KIND_READ    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_TAKEN = 2'd2;
   localparam logic [1:0] ST_SAT   = 2'd3;

   localparam logic [0:0] CSR_UNKNOWNS = 1'd0;
   localparam logic [0:0] CSR_ROWS     = 1'd1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  row_index;
      logic [4:0]  column_index;
      logic signed [31:0] operand;
      logic        last_term;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic [4:0]  out_column;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // Saturating add of a 32-bit target and a 48-bit product term.
   function automatic logic [32:0] sat_add(input logic signed [31:0] a,
                                           input logic signed [47:0] p);
      logic signed [48:0] s;
      s = 49'(a) + 49'(p);
      if (s > 49'sd2147483647) return {1'b1, 32'h7fffffff};
      if (s < -49'sd2147483648) return {1'b1, 32'h80000000};
      return {1'b0, s[31:0]};
   endfunction
endpackage

[sv/mcfrc_if.sv]
// Valid/ready channel interface carrying one word of a given payload type.
// Depends on mcfrc_pkg for the payload types.
`timescale 1ns / 1ps
interface mcfrc_req_if;
   logic valid;
   logic ready;
   mcfrc_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mcfrc_rsp_if;
   logic valid;
   logic ready;
   mcfrc_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/matrix_column_fix_and_row_combine.sv]
// Top level of the matrix column fix and row combine block.
// Depends on mcfrc_pkg and the channel interfaces in mcfrc_if.sv.
//
// Usage: request words arrive on req (valid/ready) and carry kind, row,
// column, a Q16.16 operand and last_term. Result words leave on rsp, one
// per coefficient of an emitted row or one status word for write, reserve,
// a bad combine term that is not last, and a bad read. csr_* sets the number
// of unknowns and rows; the user must write it only while the block is idle,
// which the block itself does not enforce. The matrix lives in one
// synchronous RAM of 256 x 32 words; the accumulator row and its saturation
// flags live in a second 32-word RAM. One word is in flight at a time.
// A reserve walks all rows in use with one read of the coefficient and one
// of the constant per row. A combine term walks all 32 columns; a read or a
// last term then walks the columns once more, skipping reserved and unused
// columns. Reset clears the reserved mask, restores the register defaults
// and runs a pass clearing all 32 accumulator entries, during which req is
// held off. When the receiver stalls, the output register holds its word
// and the walk waits; no result is ever dropped.
`timescale 1ns / 1ps
module matrix_column_fix_and_row_combine (
   input  logic clock,
   input  logic reset,
   mcfrc_req_if.sink   req,
   mcfrc_rsp_if.source rsp,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_write_data
);
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RES_A = 4'd2;  // read coefficient
   localparam logic [3:0] S_RES_B = 4'd3;  // read constant, multiply coefficient
   localparam logic [3:0] S_RES_C = 4'd4;  // saturating add and write back
   localparam logic [3:0] S_CMB_A = 4'd5;  // read matrix and accumulator
   localparam logic [3:0] S_CMB_B = 4'd6;  // multiply
   localparam logic [3:0] S_CMB_C = 4'd7;  // add and write accumulator
   localparam logic [3:0] S_EMT_A = 4'd8;  // read column for emission
   localparam logic [3:0] S_EMT_B = 4'd9;  // place word in output register
   localparam logic [3:0] S_STAT  = 4'd10; // status-only word

   logic [31:0] mat_mem [mcfrc_pkg::MaxRows * mcfrc_pkg::NCols];
   logic [32:0] acc_mem [mcfrc_pkg::NCols];

   logic [3:0]  state_ff, state_in;
   logic [4:0]  nu_ff, nu_in;
   logic [8:0]  nr_ff, nr_in;
   logic [30:0] mask_ff, mask_in;
   mcfrc_pkg::req_type cmd_ff, cmd_in;
   logic [8:0]  row_ff, row_in;
   logic [5:0]  col_ff, col_in;
   logic [4:0]  ocol_ff, ocol_in;
   logic        sat_ff, sat_in;
   logic        bad_ff, bad_in;
   logic        emit_acc_ff, emit_acc_in;
   logic signed [31:0] coef_ff, coef_in;
   logic signed [47:0] prod_ff, prod_in;
   logic [1:0]  stat_ff, stat_in;
   logic        ovalid_ff, ovalid_in;
   mcfrc_pkg::rsp_type odata_ff, odata_in;

   logic        mat_we, acc_we;
   logic [12:0] mat_wa, mat_ra;
   logic [31:0] mat_wd, mat_rd_ff;
   logic [4:0]  acc_wa, acc_ra;
   logic [32:0] acc_wd, acc_rd_ff;

   logic        out_free;
   logic [4:0]  emit_col;
   logic        col_last;
   logic [63:0] full_prod;
   logic [32:0] sum;

   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[mat_wa] <= mat_wd;
      mat_rd_ff <= mat_mem[mat_ra];
      if (acc_we) acc_mem[acc_wa] <= acc_wd;
      acc_rd_ff <= acc_mem[acc_ra];
   end

   assign out_free = !ovalid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.data = odata_ff;
   // Product shifted right by 16 keeps floor rounding; 48 bits hold it.
   assign full_prod = 64'(signed'(coef_ff)) * 64'(signed'(mat_rd_ff));
   assign col_last = col_ff[4:0] == 5'(mcfrc_pkg::MaxUnknowns);
   assign emit_col = col_ff[4:0];
   assign sum = mcfrc_pkg::sat_add(signed'(acc_rd_ff[31:0]), prod_ff);

   always_comb begin
      state_in = state_ff;
      nu_in = nu_ff;
      nr_in = nr_ff;
      mask_in = mask_ff;
      cmd_in = cmd_ff;
      row_in = row_ff;
      col_in = col_ff;
      ocol_in = ocol_ff;
      sat_in = sat_ff;
      bad_in = bad_ff;
      emit_acc_in = emit_acc_ff;
      coef_in = coef_ff;
      prod_in = prod_ff;
      stat_in = stat_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      odata_in = odata_ff;
      mat_we = 1'b0;
      mat_wa = {cmd_ff.row_index, cmd_ff.column_index};
      mat_wd = cmd_ff.operand;
      mat_ra = {cmd_ff.row_index, col_ff[4:0]};
      acc_we = 1'b0;
      acc_wa = col_ff[4:0];
      acc_wd = sum;
      acc_ra = col_ff[4:0];

      if (csr_write_enable) begin
         case (csr_index)
            mcfrc_pkg::CSR_UNKNOWNS: nu_in = csr_write_data[4:0];
            mcfrc_pkg::CSR_ROWS: nr_in = (csr_write_data > 9'(mcfrc_pkg::MaxRows))
               ? 9'(mcfrc_pkg::MaxRows) : csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            acc_we = 1'b1;
            acc_wd = '0;
            col_in = col_ff + 6'd1;
            if (col_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            col_in = '0;
            ocol_in = '0;
            if (req.valid && req.ready) begin
               cmd_in = req.data;
               row_in = '0;
               sat_in = 1'b0;
               state_in = S_STAT;
               case (req.data.kind)
                  mcfrc_pkg::KIND_WRITE: begin
                     stat_in = mcfrc_pkg::ST_OK;
                     if ({1'b0, req.data.row_index} >= nr_ff ||
                         (req.data.column_index != 5'd31 &&
                          req.data.column_index >= nu_ff)) begin
                        stat_in = mcfrc_pkg::ST_RANGE;
                     end else begin
                        mat_we = 1'b1;
                        mat_wa = {req.data.row_index, req.data.column_index};
                        mat_wd = req.data.operand;
                     end
                  end
                  mcfrc_pkg::KIND_RESERVE: begin
                     if (req.data.column_index >= nu_ff) begin
                        stat_in = mcfrc_pkg::ST_RANGE;
                     end else if (mask_ff[req.data.column_index]) begin
                        stat_in = mcfrc_pkg::ST_TAKEN;
                     end else if (nr_ff == 9'd0) begin
                        mask_in[req.data.column_index] = 1'b1;
                        stat_in = mcfrc_pkg::ST_OK;
                     end else begin
                        state_in = S_RES_A;
                     end
                  end
                  mcfrc_pkg::KIND_COMBINE: begin
                     bad_in = {1'b0, req.data.row_index} >= nr_ff;
                     if ({1'b0, req.data.row_index} < nr_ff) begin
                        state_in = S_CMB_A;
                     end else if (req.data.last_term) begin
                        emit_acc_in = 1'b1;
                        state_in = S_EMT_A;
                     end else begin
                        stat_in = mcfrc_pkg::ST_RANGE;
                     end
                  end
                  default: begin
                     bad_in = 1'b0;
                     if ({1'b0, req.data.row_index} < nr_ff) begin
                        emit_acc_in = 1'b0;
                        state_in = S_EMT_A;
                     end else begin
                        stat_in = mcfrc_pkg::ST_RANGE;
                     end
                  end
               endcase
            end
         end
         S_RES_A: begin
            mat_ra = {row_ff[7:0], cmd_ff.column_index};
            coef_in = cmd_ff.operand;
            state_in = S_RES_B;
         end
         S_RES_B: begin
            mat_ra = {row_ff[7:0], 5'(mcfrc_pkg::MaxUnknowns)};
            coef_in = cmd_ff.operand;
            prod_in = full_prod[63:16];
            state_in = S_RES_C;
         end
         S_RES_C: begin
            // Constant column read arrives now; product came from the previous read.
            {sat_in, mat_wd} = mcfrc_pkg::sat_add(signed'(mat_rd_ff), prod_ff);
            sat_in = sat_in || sat_ff;
            mat_we = 1'b1;
            mat_wa = {row_ff[7:0], 5'(mcfrc_pkg::MaxUnknowns)};
            row_in = row_ff + 9'd1;
            if (row_ff + 9'd1 >= nr_ff) begin
               mask_in[cmd_ff.column_index] = 1'b1;
               stat_in = (sat_in) ? mcfrc_pkg::ST_SAT : mcfrc_pkg::ST_OK;
               state_in = S_STAT;
            end else begin
               state_in = S_RES_A;
            end
         end
         S_CMB_A: begin
            coef_in = cmd_ff.operand;
            state_in = S_CMB_B;
         end
         S_CMB_B: begin
            prod_in = full_prod[63:16];
            state_in = S_CMB_C;
         end
         S_CMB_C: begin
            acc_we = 1'b1;
            acc_wd = {sum[32] | acc_rd_ff[32], sum[31:0]};
            col_in = col_ff + 6'd1;
            if (col_last) begin
               col_in = '0;
               if (cmd_ff.last_term) begin
                  emit_acc_in = 1'b1;
                  state_in = S_EMT_A;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_CMB_A;
            end
         end
         S_EMT_A: begin
            // Skip masked and unused unknown columns without waiting on the memory read.
            // The accumulator is still cleared there when the accumulator row is emitted.
            if (!col_last && (emit_col >= nu_ff || mask_ff[emit_col])) begin
               if (emit_acc_ff) begin
                  acc_we = 1'b1;
                  acc_wd = '0;
               end
               col_in = col_ff + 6'd1;
            end else begin
               state_in = S_EMT_B;
            end
         end
         S_EMT_B: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in.out_value = emit_acc_ff ? acc_rd_ff[31:0] : mat_rd_ff;
               odata_in.out_column = ocol_ff;
               odata_in.last = col_last;
               odata_in.status = bad_ff ? mcfrc_pkg::ST_RANGE
                  : (emit_acc_ff && acc_rd_ff[32]) ? mcfrc_pkg::ST_SAT
                  : mcfrc_pkg::ST_OK;
               if (emit_acc_ff) begin
                  acc_we = 1'b1;
                  acc_wd = '0;
               end
               ocol_in = ocol_ff + 5'd1;
               col_in = col_ff + 6'd1;
               state_in = col_last ? S_IDLE : S_EMT_A;
            end
         end
         S_STAT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in = '{out_value: '0, out_column: '0, status: stat_ff, last: 1'b1};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         nu_ff <= 5'd31;
         nr_ff <= 9'(mcfrc_pkg::MaxRows);
         mask_ff <= '0;
         col_ff <= '0;
         ovalid_ff <= 1'b0;
         emit_acc_ff <= 1'b0;
         bad_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         nu_ff <= nu_in;
         nr_ff <= nr_in;
         mask_ff <= mask_in;
         col_ff <= col_in;
         ovalid_ff <= ovalid_in;
         emit_acc_ff <= emit_acc_in;
         bad_ff <= bad_in;
      end
      cmd_ff <= cmd_in;
      row_ff <= row_in;
      ocol_ff <= ocol_in;
      sat_ff <= sat_in;
      coef_ff <= coef_in;
      prod_ff <= prod_in;
      stat_ff <= stat_in;
      odata_ff <= odata_in;
   end
endmodule

[sv/mcfrc_checker.sv]
// Port-level checker for the matrix column fix and row combine block.
// Depends on mcfrc_pkg and the channel interfaces; bound to the top level.
`timescale 1ns / 1ps
module mcfrc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input mcfrc_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");
   a_no_take_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result waits");
   a_status_only_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == mcfrc_pkg::ST_TAKEN |->
      rsp_data.last && rsp_data.out_column == 5'd0)
      else $error("reserve error word is not a single status word");
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");
endmodule

bind matrix_column_fix_and_row_combine mcfrc_checker u_mcfrc_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

[test/testbench.sv]
// Testbench for the matrix column fix and row combine block.
// Depends on mcfrc_pkg, the channel interfaces in mcfrc_if.sv and the top level.
`timescale 1ns / 1ps
module testbench;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = mcfrc_pkg::CSR_UNKNOWNS;
   logic [8:0] csr_write_data = '0;

   mcfrc_req_if req();
   mcfrc_rsp_if rsp();

   matrix_column_fix_and_row_combine dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the block's state.
   logic signed [31:0] matrix_copy [mcfrc_pkg::MaxRows][mcfrc_pkg::NCols];
   bit                 written [mcfrc_pkg::MaxRows][mcfrc_pkg::NCols];
   logic [30:0]        masked_cols;
   logic signed [31:0] sum_row [mcfrc_pkg::NCols];
   bit                 sum_sat [mcfrc_pkg::NCols];
   int                 unknowns_in_use;
   int                 rows_in_use;

   mcfrc_pkg::rsp_type expected_words[$];
   int  fail_count = 0;
   bit  rsp_stall_on = 1'b1;
   bit  req_idle_on = 1'b1;

   // Floor of a Q16.16 product, added at full precision and saturated.
   function automatic logic signed [31:0] mac_sat(input logic signed [31:0] acc,
                                                  input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  inout bit sat);
      logic signed [63:0] prod;
      logic signed [64:0] total;
      prod = 64'(a) * 64'(b);
      total = 65'(acc) + 65'(prod >>> 16);
      if (total > 65'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (total < -65'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return total[31:0];
   endfunction

   function automatic void push_status(input logic [1:0] st);
      mcfrc_pkg::rsp_type w;
      w = '{out_value: '0, out_column: '0, status: st, last: 1'b1};
      expected_words.push_back(w);
   endfunction

   function automatic logic signed [31:0] entry(input int r, input int c);
      return written[r][c] ? matrix_copy[r][c] : 32'sd0;
   endfunction

   // Emits the compacted row given by values, status per column.
   function automatic void push_row(input logic signed [31:0] vals [mcfrc_pkg::NCols],
                                    input logic [1:0] sts [mcfrc_pkg::NCols]);
      mcfrc_pkg::rsp_type w;
      int n;
      n = 0;
      for (int c = 0; c < unknowns_in_use; c++) begin
         if (!masked_cols[c]) begin
            w = '{out_value: vals[c], out_column: 5'(n), status: sts[c], last: 1'b0};
            expected_words.push_back(w);
            n++;
         end
      end
      w = '{out_value: vals[mcfrc_pkg::MaxUnknowns], out_column: 5'(n),
            status: sts[mcfrc_pkg::MaxUnknowns], last: 1'b1};
      expected_words.push_back(w);
   endfunction

   function automatic void predict_word(input mcfrc_pkg::req_type q);
      bit row_ok, sat;
      int col;
      logic signed [31:0] vals [mcfrc_pkg::NCols];
      logic [1:0] sts [mcfrc_pkg::NCols];
      row_ok = q.row_index < rows_in_use;
      col = q.column_index;
      case (q.kind)
         mcfrc_pkg::KIND_WRITE: begin
            if (!row_ok || !(col == 31 || col < unknowns_in_use))
               push_status(mcfrc_pkg::ST_RANGE);
            else begin
               if (col == 31) col = mcfrc_pkg::MaxUnknowns;
               matrix_copy[q.row_index][col] = q.operand;
               written[q.row_index][col] = 1'b1;
               push_status(mcfrc_pkg::ST_OK);
            end
         end
         mcfrc_pkg::KIND_RESERVE: begin
            sat = 1'b0;
            if (col >= unknowns_in_use) push_status(mcfrc_pkg::ST_RANGE);
            else if (masked_cols[col]) push_status(mcfrc_pkg::ST_TAKEN);
            else begin
               for (int r = 0; r < rows_in_use; r++) begin
                  matrix_copy[r][mcfrc_pkg::MaxUnknowns] =
                     mac_sat(entry(r, mcfrc_pkg::MaxUnknowns), entry(r, col),
                             q.operand, sat);
                  written[r][mcfrc_pkg::MaxUnknowns] = 1'b1;
               end
               masked_cols[col] = 1'b1;
               push_status(sat ? mcfrc_pkg::ST_SAT : mcfrc_pkg::ST_OK);
            end
         end
         mcfrc_pkg::KIND_COMBINE: begin
            if (row_ok)
               for (int c = 0; c < mcfrc_pkg::NCols; c++)
                  sum_row[c] = mac_sat(sum_row[c], q.operand, entry(q.row_index, c),
                                       sum_sat[c]);
            if (!q.last_term) begin
               if (!row_ok) push_status(mcfrc_pkg::ST_RANGE);
            end else begin
               for (int c = 0; c < mcfrc_pkg::NCols; c++) begin
                  vals[c] = sum_row[c];
                  sts[c] = !row_ok ? mcfrc_pkg::ST_RANGE
                     : (sum_sat[c] ? mcfrc_pkg::ST_SAT : mcfrc_pkg::ST_OK);
                  sum_row[c] = '0;
                  sum_sat[c] = 1'b0;
               end
               push_row(vals, sts);
            end
         end
         default: begin
            if (!row_ok) push_status(mcfrc_pkg::ST_RANGE);
            else begin
               for (int c = 0; c < mcfrc_pkg::NCols; c++) begin
                  vals[c] = entry(q.row_index, c);
                  sts[c] = mcfrc_pkg::ST_OK;
               end
               push_row(vals, sts);
            end
         end
      endcase
   endfunction

   // Result side: random stall bursts, compare at the rising edge.
   initial begin
      int burst;
      rsp.ready = 1'b0;
      burst = 0;
      @(negedge clock);
      forever begin
         if (burst > 0) begin
            rsp.ready <= 1'b0;
            burst--;
         end else if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            burst = $urandom_range(0, 3);
         end else rsp.ready <= 1'b1;
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word value=%0d", rsp.data.out_value);
               fail_count++;
            end else begin
               mcfrc_pkg::rsp_type e;
               e = expected_words.pop_front();
               if (rsp.data.out_value !== e.out_value) begin
                  $error("out_value expected %0d actual %0d", e.out_value,
                         rsp.data.out_value);
                  fail_count++;
               end
               if (rsp.data.out_column !== e.out_column) begin
                  $error("out_column expected %0d actual %0d", e.out_column,
                         rsp.data.out_column);
                  fail_count++;
               end
               if (rsp.data.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp.data.status);
                  fail_count++;
               end
               if (rsp.data.last !== e.last) begin
                  $error("last expected %0d actual %0d", e.last, rsp.data.last);
                  fail_count++;
               end
            end
         end
         @(negedge clock);
      end
   end

   // Sends one word, with an optional idle burst first. Valid stays high
   // until the next word or until the caller goes idle.
   task automatic send_word(input mcfrc_pkg::req_type q);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.data <= q;
      do @(posedge clock); while (!req.ready);
      predict_word(q);
      @(negedge clock);
   endtask

   // Drains outstanding results, then lets the walk settle before a register write.
   task automatic wait_idle();
      req.valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_register(input logic [0:0] index, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= 9'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == mcfrc_pkg::CSR_UNKNOWNS) unknowns_in_use = value;
      else rows_in_use = value;
   endtask

   function automatic mcfrc_pkg::req_type make_word(input logic [1:0] k, input int r,
                                                    input int c, input logic [31:0] v,
                                                    input bit lt);
      mcfrc_pkg::req_type q;
      q.kind = k;
      q.row_index = 8'(r);
      q.column_index = 5'(c);
      q.operand = v;
      q.last_term = lt;
      return q;
   endfunction

   // A row is readable once every column in use and the constant are written.
   function automatic bit row_filled(input int r);
      for (int c = 0; c < mcfrc_pkg::NCols; c++)
         if ((c < unknowns_in_use || c == mcfrc_pkg::MaxUnknowns) && !written[r][c])
            return 1'b0;
      return 1'b1;
   endfunction

   // A combine term reads every stored column of its row.
   function automatic bit row_complete(input int r);
      for (int c = 0; c < mcfrc_pkg::NCols; c++)
         if (!written[r][c]) return 1'b0;
      return 1'b1;
   endfunction

   // Writes every column in use, and the constant, of each row in use not yet readable.
   task automatic fill_matrix();
      for (int r = 0; r < rows_in_use; r++) begin
         if (row_filled(r)) continue;
         for (int c = 0; c < unknowns_in_use; c++)
            send_word(make_word(mcfrc_pkg::KIND_WRITE, r, c, $urandom_range(0, 3) == 0 ?
                                32'($urandom) : 32'($signed($urandom_range(0, 8'hff)) -
                                128) <<< $urandom_range(8, 18), 1'b0));
         send_word(make_word(mcfrc_pkg::KIND_WRITE, r, 31, $urandom, 1'b0));
      end
   endtask

   task automatic random_word();
      int r, k;
      r = ($urandom_range(0, 9) == 0 || rows_in_use == 0) ? $urandom_range(0, 255) :
          $urandom_range(0, rows_in_use - 1);
      k = $urandom_range(0, 9);
      // Out-of-range rows are safe; in-range rows must be written where read.
      if (r < rows_in_use && k >= 3 && k < 7 && !row_complete(r))
         k = 7;
      if (r < rows_in_use && k >= 7 && k != 9 && !row_filled(r))
         k = 0;
      if (k < 3)
         send_word(make_word(mcfrc_pkg::KIND_WRITE, r, $urandom_range(0, 31), $urandom,
                             1'b0));
      else if (k < 7)
         send_word(make_word(mcfrc_pkg::KIND_COMBINE, r, $urandom,
                             $urandom_range(0, 1) ? $urandom : 32'sh00010000 >>>
                             $urandom_range(0, 4), $urandom_range(0, 2) == 0));
      else if (k < 9)
         send_word(make_word(mcfrc_pkg::KIND_READ, r, $urandom, $urandom, $urandom));
      else begin
         // A reserve touches every row in use; only issue it on a full matrix.
         bit full;
         full = 1'b1;
         for (int i = 0; i < rows_in_use; i++) full &= row_filled(i);
         if (full)
            send_word(make_word(mcfrc_pkg::KIND_RESERVE, $urandom, $urandom_range(0, 31),
                                $urandom, 1'b0));
         else
            send_word(make_word(mcfrc_pkg::KIND_READ, 255, 0, 0, 1'b0));
      end
   endtask

   typedef struct {
      mcfrc_pkg::req_type q;
      bit                 typed;
      mcfrc_pkg::rsp_type w;
   } stim_row;

   initial begin
      stim_row plan[$];
      req.valid = 1'b0;
      req.data = '0;
      masked_cols = '0;
      unknowns_in_use = 31;
      rows_in_use = 256;
      foreach (sum_row[c]) begin
         sum_row[c] = '0;
         sum_sat[c] = 1'b0;
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed phase: small matrix, extremes and every error path.
      // Both rows are first written in every column so combines read no gaps.
      write_register(mcfrc_pkg::CSR_ROWS, 2);
      fill_matrix();
      wait_idle();
      write_register(mcfrc_pkg::CSR_UNKNOWNS, 3);
      plan = '{
         '{make_word(mcfrc_pkg::KIND_WRITE, 0, 0, 32'sh7fffffff, 0), 1,
           '{0, 0, mcfrc_pkg::ST_OK, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 0, 1, 32'sh80000000, 0), 1,
           '{0, 0, mcfrc_pkg::ST_OK, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 0, 2, 32'sh00010000, 0), 1,
           '{0, 0, mcfrc_pkg::ST_OK, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 0, 31, 32'shfffe0000, 0), 1,
           '{0, 0, mcfrc_pkg::ST_OK, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 1, 0, 32'sh00020000, 0), 1,
           '{0, 0, mcfrc_pkg::ST_OK, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 1, 1, 32'sh00008000, 0), 1,
           '{0, 0, mcfrc_pkg::ST_OK, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 1, 2, 32'sh00000000, 0), 1,
           '{0, 0, mcfrc_pkg::ST_OK, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 1, 31, 32'sh7fff0000, 0), 1,
           '{0, 0, mcfrc_pkg::ST_OK, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 2, 0, 0, 0), 1,
           '{0, 0, mcfrc_pkg::ST_RANGE, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 255, 31, 32'hffffffff, 1), 1,
           '{0, 0, mcfrc_pkg::ST_RANGE, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 0, 3, 0, 0), 1,
           '{0, 0, mcfrc_pkg::ST_RANGE, 1}},
         '{make_word(mcfrc_pkg::KIND_READ, 0, 0, 0, 0), 0, '{0, 0, 0, 0}},
         '{make_word(mcfrc_pkg::KIND_READ, 200, 0, 0, 0), 1,
           '{0, 0, mcfrc_pkg::ST_RANGE, 1}},
         '{make_word(mcfrc_pkg::KIND_COMBINE, 0, 0, 32'sh00010000, 0), 0, '{0, 0, 0, 0}},
         '{make_word(mcfrc_pkg::KIND_COMBINE, 9, 0, 32'sh00010000, 0), 1,
           '{0, 0, mcfrc_pkg::ST_RANGE, 1}},
         '{make_word(mcfrc_pkg::KIND_COMBINE, 1, 0, 32'sh7fffffff, 1), 0, '{0, 0, 0, 0}},
         '{make_word(mcfrc_pkg::KIND_COMBINE, 0, 0, 32'sh80000000, 0), 0, '{0, 0, 0, 0}},
         '{make_word(mcfrc_pkg::KIND_COMBINE, 128, 31, 32'sh00010000, 1), 0,
           '{0, 0, 0, 0}},
         '{make_word(mcfrc_pkg::KIND_RESERVE, 0, 1, 32'sh00030000, 0), 0, '{0, 0, 0, 0}},
         '{make_word(mcfrc_pkg::KIND_RESERVE, 0, 1, 32'sh00010000, 0), 1,
           '{0, 0, mcfrc_pkg::ST_TAKEN, 1}},
         '{make_word(mcfrc_pkg::KIND_RESERVE, 0, 31, 0, 0), 1,
           '{0, 0, mcfrc_pkg::ST_RANGE, 1}},
         '{make_word(mcfrc_pkg::KIND_RESERVE, 0, 3, 0, 0), 1,
           '{0, 0, mcfrc_pkg::ST_RANGE, 1}},
         '{make_word(mcfrc_pkg::KIND_WRITE, 1, 1, 32'sh00050000, 0), 1,
           '{0, 0, mcfrc_pkg::ST_OK, 1}},
         '{make_word(mcfrc_pkg::KIND_READ, 1, 0, 0, 0), 0, '{0, 0, 0, 0}},
         '{make_word(mcfrc_pkg::KIND_COMBINE, 1, 0, 32'shffff0000, 1), 0, '{0, 0, 0, 0}}
      };
      foreach (plan[i]) begin
         send_word(plan[i].q);
         // Typed rows override the predictor's entry with the value read off at a glance.
         if (plan[i].typed) begin
            void'(expected_words.pop_back());
            expected_words.push_back(plan[i].w);
         end
      end

      // Random phases across register settings, extremes included.
      for (int phase = 0; phase < 5; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_register(mcfrc_pkg::CSR_UNKNOWNS, 1);
               write_register(mcfrc_pkg::CSR_ROWS, 1);
            end
            1: begin
               write_register(mcfrc_pkg::CSR_UNKNOWNS, 31);
               write_register(mcfrc_pkg::CSR_ROWS, 3);
            end
            2: begin
               write_register(mcfrc_pkg::CSR_UNKNOWNS, 0);
               write_register(mcfrc_pkg::CSR_ROWS, 256);
            end
            3: begin
               write_register(mcfrc_pkg::CSR_UNKNOWNS, 5);
               write_register(mcfrc_pkg::CSR_ROWS, 4);
            end
            default: begin
               write_register(mcfrc_pkg::CSR_UNKNOWNS, 31);
               write_register(mcfrc_pkg::CSR_ROWS, 0);
            end
         endcase
         if (phase == 4) begin
            rsp_stall_on = 1'b0;
            req_idle_on = 1'b0;
         end
         if (rows_in_use > 0 && rows_in_use <= 4) fill_matrix();
         repeat (phase == 2 ? 10 : 20) random_word();
      end

      req.valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end
endmodule

[files.f]
sv/mcfrc_pkg.sv
sv/mcfrc_if.sv
sv/matrix_column_fix_and_row_combine.sv
sv/mcfrc_checker.sv
test/testbench.sv
